// ===== design/stt_pkg.sv =====
// shared types, codes and constants of the software timer table
package stt_pkg;

    // default number of timer slots and range limits
    localparam int TIMER_SLOTS_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;    // power of two, pointers wrap naturally

    // field widths
    localparam int FUNC_W   = 3;
    localparam int ID_W     = 4;
    localparam int PERIOD_W = 25;
    localparam int TICK_W   = 10;
    localparam int STATUS_W = 2;

    localparam logic [TICK_W-1:0] TICK_LEN_RESET = 10'd100;

    // function codes on the input stream
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_CREATE  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESET   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DESTROY = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_ANSWER  = 3'd4;

    // completion status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_ID  = 2'd2;

    // result kinds
    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_FIRE = 1'b1;

    // classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_CREATE  = 3'd1,
        OP_RESET   = 3'd2,
        OP_DESTROY = 3'd3,
        OP_ANSWER  = 3'd4,
        OP_BAD     = 3'd5,
        OP_NOP     = 3'd6
    } t_op;

    // per-slot lifecycle
    typedef enum logic [1:0] {
        SLOT_IDLE     = 2'd0,
        SLOT_RUNNING  = 2'd1,
        SLOT_STOPPED  = 2'd2,
        SLOT_WAIT_DEL = 2'd3
    } t_slot;

    typedef struct packed {
        t_op                        op;
        logic [ID_W-1:0]            slot_id;
        logic signed [PERIOD_W-1:0] period;
        logic                       keep;
    } t_cmd;

    // queue status seen by the back end
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

// ===== design/software_timer_table.sv =====
// top level of the software timer table
// A table of TimerSlots periodic timers driven by command transfers. Up to two
// commands are buffered in front of the sequencer, so the input stays ready while
// a command executes. A tick walks the whole table slot by slot (a
// registered read of the period and elapsed memories, then the update); it
// emits one fire event per expiring slot in slot order, then its completion. A
// create scans the slot states one per cycle. Reset, destroy, answer and unused
// codes pass through the execute state straight to their completion. Every
// command ends with a completion carrying tlast. The tick length register may be
// written only while no command is in flight.
module software_timer_table #(
    parameter int TimerSlots = stt_pkg::TIMER_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic [stt_pkg::TICK_W-1:0]    i_cfg_wr_data,    // tick_length_ms
    // command stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,     // slot_id[3:0], period_ms[28:4], keep_running[29]
    input  logic [2:0]                    s_axis_tuser,     // func[2:0]
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,     // slot_index[3:0], status[5:4]
    output logic [0:0]                    m_axis_tuser,     // kind[0]
    output logic                          m_axis_tlast
);

    logic [stt_pkg::TICK_W-1:0]    r_tick_len;
    logic                          w_push;
    logic                          w_pop;
    stt_pkg::t_cmd                 w_front_cmd;
    stt_pkg::t_cmd                 w_q_cmd;
    stt_pkg::t_q_stat              w_q_stat;
    logic                          w_out_kind;
    logic [stt_pkg::ID_W-1:0]      w_out_idx;
    logic [stt_pkg::STATUS_W-1:0]  w_out_status;

    // tick length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_len <= stt_pkg::TICK_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_tick_len <= i_cfg_wr_data;
        end
    end

    stt_front #(
        .TimerSlots (TimerSlots)
    ) u_front (
        .i_valid  (s_axis_tvalid),
        .i_data   (s_axis_tdata),
        .i_user   (s_axis_tuser),
        .i_q_stat (w_q_stat),
        .o_ready  (s_axis_tready),
        .o_push   (w_push),
        .o_cmd    (w_front_cmd)
    );

    stt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_cmd),
        .i_pop   (w_pop),
        .o_data  (w_q_cmd),
        .o_stat  (w_q_stat)
    );

    stt_back #(
        .TimerSlots (TimerSlots)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick_len   (r_tick_len),
        .i_cmd        (w_q_cmd),
        .i_q_stat     (w_q_stat),
        .o_pop        (w_pop),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_kind   (w_out_kind),
        .o_out_idx    (w_out_idx),
        .o_out_status (w_out_status),
        .o_out_last   (m_axis_tlast)
    );

    // result packing
    assign m_axis_tdata = {2'b00, w_out_status, w_out_idx};
    assign m_axis_tuser = w_out_kind;

endmodule

// ===== design/stt_front.sv =====
// front end: takes input transfers, unpacks and classifies them into commands
module stt_front #(
    parameter int TimerSlots = stt_pkg::TIMER_SLOTS_DEF
) (
    input  logic                          i_valid,
    input  logic [31:0]                   i_data,
    input  logic [stt_pkg::FUNC_W-1:0]    i_user,
    input  stt_pkg::t_q_stat              i_q_stat,
    output logic                          o_ready,
    output logic                          o_push,
    output stt_pkg::t_cmd                 o_cmd
);

    logic [stt_pkg::ID_W-1:0] w_id;
    logic                     w_id_bad;

    // handshake against queue space
    assign o_ready = !i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;

    // field unpacking
    assign w_id     = i_data[3:0];
    assign w_id_bad = {28'd0, w_id} >= 32'(TimerSlots);

    // classification
    always_comb begin
        o_cmd.slot_id = w_id;
        o_cmd.period  = i_data[28:4];
        o_cmd.keep    = i_data[29];
        unique case (i_user)
            stt_pkg::FUNC_TICK:    o_cmd.op = stt_pkg::OP_TICK;
            stt_pkg::FUNC_CREATE:  o_cmd.op = stt_pkg::OP_CREATE;
            stt_pkg::FUNC_RESET:   o_cmd.op = w_id_bad ? stt_pkg::OP_BAD : stt_pkg::OP_RESET;
            stt_pkg::FUNC_DESTROY: o_cmd.op = w_id_bad ? stt_pkg::OP_BAD : stt_pkg::OP_DESTROY;
            stt_pkg::FUNC_ANSWER:  o_cmd.op = w_id_bad ? stt_pkg::OP_BAD : stt_pkg::OP_ANSWER;
            default:               o_cmd.op = stt_pkg::OP_NOP;
        endcase
    end

endmodule

// ===== design/stt_fifo.sv =====
// short command queue between front and back end
module stt_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  stt_pkg::t_cmd     i_data,
    input  logic              i_pop,
    output stt_pkg::t_cmd     o_data,
    output stt_pkg::t_q_stat  o_stat
);

    localparam int Depth = stt_pkg::QUEUE_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;

    stt_pkg::t_cmd   r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [PtrW:0]   r_count;

    assign o_data      = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == (PtrW+1)'(Depth));

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PtrW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PtrW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PtrW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (PtrW+1)'(1);
            end
        end
    end

endmodule

// ===== design/stt_back.sv =====
// back end: slot table, command sequencer and result register
module stt_back #(
    parameter int TimerSlots = stt_pkg::TIMER_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [stt_pkg::TICK_W-1:0]      i_tick_len,
    input  stt_pkg::t_cmd                   i_cmd,
    input  stt_pkg::t_q_stat                i_q_stat,
    output logic                            o_pop,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_out_kind,
    output logic [stt_pkg::ID_W-1:0]        o_out_idx,
    output logic [stt_pkg::STATUS_W-1:0]    o_out_status,
    output logic                            o_out_last
);

    localparam int SlotW = (TimerSlots > 1) ? $clog2(TimerSlots) : 1;
    localparam logic [SlotW-1:0] LastIdx = SlotW'(TimerSlots - 1);
    localparam int PW = stt_pkg::PERIOD_W;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_EXEC    = 6'b000010,
        S_CREATE  = 6'b000100,
        S_TICK_RD = 6'b001000,
        S_TICK_EV = 6'b010000,
        S_DONE    = 6'b100000
    } t_fsm;

    t_fsm                          r_fsm, n_fsm;
    stt_pkg::t_cmd                 r_cmd, n_cmd;
    logic [SlotW-1:0]              r_idx, n_idx;
    logic [stt_pkg::ID_W-1:0]      r_res_idx, n_res_idx;
    logic [stt_pkg::STATUS_W-1:0]  r_res_status, n_res_status;

    stt_pkg::t_slot                r_state [TimerSlots];
    logic [TimerSlots-1:0]         r_await;
    logic [PW-1:0]                 r_per_mem [TimerSlots];
    logic [PW-1:0]                 r_el_mem  [TimerSlots];
    logic [PW-1:0]                 r_per_q;
    logic [PW-1:0]                 r_el_q;

    logic                          r_out_valid;
    logic                          r_out_kind;
    logic [stt_pkg::ID_W-1:0]      r_out_idx;
    logic [stt_pkg::STATUS_W-1:0]  r_out_status;
    logic                          r_out_last;

    // table write controls
    logic                          w_st_we;
    logic [SlotW-1:0]              w_st_wa;
    stt_pkg::t_slot                w_st_wd;
    logic                          w_aw_we;
    logic                          w_aw_wd;
    logic                          w_per_we;
    logic                          w_el_we;
    logic [SlotW-1:0]              w_mem_wa;
    logic [PW-1:0]                 w_el_wd;

    // result register load
    logic                          w_out_free;
    logic                          w_out_load;
    logic                          w_out_kind;
    logic [stt_pkg::ID_W-1:0]      w_out_idx;
    logic [stt_pkg::STATUS_W-1:0]  w_out_status;
    logic                          w_out_last;

    // tick arithmetic for the slot under scan
    logic [SlotW-1:0]              w_id;
    logic [PW:0]                   w_sum;
    logic [PW-1:0]                 w_el_next;
    logic                          w_counts;
    logic                          w_expire;

    assign w_id       = SlotW'(r_cmd.slot_id);
    assign w_sum      = {1'b0, r_el_q} + (PW+1)'(i_tick_len);
    assign w_el_next  = w_sum[PW-1:0];
    assign w_counts   = (r_state[r_idx] == stt_pkg::SLOT_RUNNING) && !r_per_q[PW-1]
                        && !r_await[r_idx];
    assign w_expire   = w_el_next > r_per_q;
    assign w_out_free = !r_out_valid || i_out_ready;

    // command sequencer
    always_comb begin
        n_fsm        = r_fsm;
        n_cmd        = r_cmd;
        n_idx        = r_idx;
        n_res_idx    = r_res_idx;
        n_res_status = r_res_status;
        o_pop        = 1'b0;
        w_st_we      = 1'b0;
        w_st_wa      = r_idx;
        w_st_wd      = stt_pkg::SLOT_RUNNING;
        w_aw_we      = 1'b0;
        w_aw_wd      = 1'b0;
        w_per_we     = 1'b0;
        w_el_we      = 1'b0;
        w_mem_wa     = r_idx;
        w_el_wd      = '0;
        w_out_load   = 1'b0;
        w_out_kind   = stt_pkg::KIND_DONE;
        w_out_idx    = r_res_idx;
        w_out_status = r_res_status;
        w_out_last   = 1'b1;
        unique case (r_fsm)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    n_idx = '0;
                    case (i_cmd.op)
                        stt_pkg::OP_TICK:   n_fsm = S_TICK_RD;
                        stt_pkg::OP_CREATE: n_fsm = S_CREATE;
                        default:            n_fsm = S_EXEC;
                    endcase
                end
            end
            S_EXEC: begin
                n_res_idx    = r_cmd.slot_id;
                n_res_status = stt_pkg::STATUS_OK;
                w_st_wa      = w_id;
                w_mem_wa     = w_id;
                case (r_cmd.op)
                    stt_pkg::OP_RESET: begin
                        w_per_we = 1'b1;
                        w_el_we  = 1'b1;
                        w_st_we  = 1'b1;
                        w_aw_we  = 1'b1;
                    end
                    stt_pkg::OP_DESTROY: begin
                        w_st_we = 1'b1;
                        w_st_wd = stt_pkg::SLOT_WAIT_DEL;
                        w_aw_we = 1'b1;
                    end
                    stt_pkg::OP_ANSWER: begin
                        // stray answers leave the slot alone
                        if (r_await[w_id] && r_state[w_id] == stt_pkg::SLOT_RUNNING) begin
                            w_aw_we = 1'b1;
                            w_st_we = !r_cmd.keep;
                            w_st_wd = stt_pkg::SLOT_STOPPED;
                        end
                    end
                    stt_pkg::OP_BAD: begin
                        n_res_idx    = '0;
                        n_res_status = stt_pkg::STATUS_BAD_ID;
                    end
                    default: begin
                        n_res_idx = '0;
                    end
                endcase
                n_fsm = S_DONE;
            end
            S_CREATE: begin
                // lowest idle slot, one slot per cycle
                if (r_state[r_idx] == stt_pkg::SLOT_IDLE) begin
                    w_per_we     = 1'b1;
                    w_el_we      = 1'b1;
                    w_st_we      = 1'b1;
                    w_aw_we      = 1'b1;
                    n_res_idx    = stt_pkg::ID_W'(r_idx);
                    n_res_status = stt_pkg::STATUS_OK;
                    n_fsm        = S_DONE;
                end else if (r_idx == LastIdx) begin
                    n_res_idx    = '0;
                    n_res_status = stt_pkg::STATUS_NO_FREE;
                    n_fsm        = S_DONE;
                end else begin
                    n_idx = r_idx + SlotW'(1);
                end
            end
            S_TICK_RD: begin
                n_fsm = S_TICK_EV;
            end
            S_TICK_EV: begin
                if (w_counts && w_expire) begin
                    // fire event waits for the result register
                    if (w_out_free) begin
                        w_out_load   = 1'b1;
                        w_out_kind   = stt_pkg::KIND_FIRE;
                        w_out_idx    = stt_pkg::ID_W'(r_idx);
                        w_out_status = stt_pkg::STATUS_OK;
                        w_out_last   = 1'b0;
                        w_el_we      = 1'b1;
                        w_aw_we      = 1'b1;
                        w_aw_wd      = 1'b1;
                    end
                end else if (w_counts) begin
                    w_el_we = 1'b1;
                    w_el_wd = w_el_next;
                end else if (r_state[r_idx] == stt_pkg::SLOT_WAIT_DEL) begin
                    w_st_we = 1'b1;
                    w_st_wd = stt_pkg::SLOT_IDLE;
                end
                if (!(w_counts && w_expire) || w_out_free) begin
                    if (r_idx == LastIdx) begin
                        n_res_idx    = '0;
                        n_res_status = stt_pkg::STATUS_OK;
                        n_fsm        = S_DONE;
                    end else begin
                        n_idx = r_idx + SlotW'(1);
                        n_fsm = S_TICK_RD;
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_fsm      = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= S_IDLE;
            r_idx <= '0;
        end else begin
            r_fsm <= n_fsm;
            r_idx <= n_idx;
        end
    end

    // command and result payload
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_res_idx    <= n_res_idx;
        r_res_status <= n_res_status;
    end

    // slot state and answer flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TimerSlots; i++) begin
                r_state[i] <= stt_pkg::SLOT_IDLE;
            end
            r_await <= '0;
        end else begin
            if (w_st_we) begin
                r_state[w_st_wa] <= w_st_wd;
            end
            if (w_aw_we) begin
                r_await[w_st_wa] <= w_aw_wd;
            end
        end
    end

    // period and elapsed memories, registered read at the scan index
    always_ff @(posedge i_clk) begin
        if (w_per_we) begin
            r_per_mem[w_mem_wa] <= r_cmd.period;
        end
        if (w_el_we) begin
            r_el_mem[w_mem_wa] <= w_el_wd;
        end
        r_per_q <= r_per_mem[r_idx];
        r_el_q  <= r_el_mem[r_idx];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_kind   <= w_out_kind;
            r_out_idx    <= w_out_idx;
            r_out_status <= w_out_status;
            r_out_last   <= w_out_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_kind   = r_out_kind;
    assign o_out_idx    = r_out_idx;
    assign o_out_status = r_out_status;
    assign o_out_last   = r_out_last;

endmodule

// ===== design/stt_checker.sv =====
// port-level checks of the software timer table, bound to the top level
module stt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [0:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    // a stalled result transfer holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // fire events never close a command
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tlast)
        else $error("fire event flagged as last");

    // every completion closes its command
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
        else $error("completion without last");

    // fire events carry status ok, and status never takes an unused code
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[5:4] != 2'd3)
            && (!m_axis_tuser[0] || m_axis_tdata[5:4] == 2'd0)
            && (m_axis_tdata[7:6] == 2'd0))
        else $error("bad status on result");

endmodule

bind software_timer_table stt_checker u_stt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== dv/tb_software_timer_table.sv =====
// self-checking testbench for the software timer table
module tb_software_timer_table;
    import stt_pkg::*;

    localparam int SLOTS       = TIMER_SLOTS_DEF;
    localparam int SETTLE      = 2 * SLOTS + 8;   // longest command without output stalls
    localparam int QUIET_LIMIT = 3000;            // well above the long receiver hold-off
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [FUNC_W-1:0]          func;
        logic [ID_W-1:0]            slot_id;
        logic signed [PERIOD_W-1:0] period;
        logic                       keep;
    } timer_cmd_t;

    typedef struct {
        logic                kind;
        logic [ID_W-1:0]     slot_index;
        logic [STATUS_W-1:0] status;
        logic                last;
    } timer_result_t;

    // dut ports, inputs known from time zero
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [TICK_W-1:0]    i_cfg_wr_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata = '0;    // slot_id[3:0], period_ms[28:4], keep_running[29]
    logic [2:0]           s_axis_tuser = '0;    // func[2:0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;         // slot_index[3:0], status[5:4]
    logic [0:0]           m_axis_tuser;         // kind[0]
    logic                 m_axis_tlast;

    // timer table shadow
    t_slot             tm_state[SLOTS];
    int                tm_period[SLOTS];
    int                tm_elapsed[SLOTS];
    bit                tm_waiting[SLOTS];
    logic [TICK_W-1:0] tm_tick_len;

    timer_cmd_t    cmd_backlog[$];
    timer_result_t due_results[$];
    timer_cmd_t    cur_cmd;

    int n_issued = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_fires = 0;
    int n_errors = 0;
    int n_cfg_writes = 0;
    int quiet_cycles = 0;
    int stall_left = 0;
    bit calm = 1'b0;
    bit hold_request = 1'b0;
    bit hold_done = 1'b0;

    software_timer_table #(
        .TimerSlots(SLOTS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        n_errors++;
    endtask

    task automatic expect_result(input logic kind, input int idx,
                                 input logic [STATUS_W-1:0] status, input logic last);
        timer_result_t r;
        r.kind       = kind;
        r.slot_index = idx[ID_W-1:0];
        r.status     = status;
        r.last       = last;
        due_results.push_back(r);
    endtask

    task automatic arm_slot(input int idx, input int period);
        tm_period[idx]  = period;
        tm_elapsed[idx] = 0;
        tm_waiting[idx] = 1'b0;
        tm_state[idx]   = SLOT_RUNNING;
    endtask

    // table update and expected results for one accepted command
    task automatic apply_timer_cmd(input timer_cmd_t c);
        int e;
        int free_slot;
        free_slot = -1;
        case (c.func)
            FUNC_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (tm_state[i] == SLOT_RUNNING) begin
                        if (tm_period[i] >= 0 && !tm_waiting[i]) begin
                            e = (tm_elapsed[i] + int'(tm_tick_len)) & 32'h01FF_FFFF;
                            if (e > tm_period[i]) begin
                                tm_elapsed[i] = 0;
                                tm_waiting[i] = 1'b1;
                                expect_result(KIND_FIRE, i, STATUS_OK, 1'b0);
                            end else begin
                                tm_elapsed[i] = e;
                            end
                        end
                    end else if (tm_state[i] == SLOT_WAIT_DEL) begin
                        tm_state[i] = SLOT_IDLE;
                    end
                end
                expect_result(KIND_DONE, 0, STATUS_OK, 1'b1);
            end
            FUNC_CREATE: begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (tm_state[i] == SLOT_IDLE) free_slot = i;
                if (free_slot >= 0) begin
                    arm_slot(free_slot, int'(c.period));
                    expect_result(KIND_DONE, free_slot, STATUS_OK, 1'b1);
                end else begin
                    expect_result(KIND_DONE, 0, STATUS_NO_FREE, 1'b1);
                end
            end
            FUNC_RESET, FUNC_DESTROY, FUNC_ANSWER: begin
                if (int'(c.slot_id) >= SLOTS) begin
                    expect_result(KIND_DONE, 0, STATUS_BAD_ID, 1'b1);
                end else begin
                    if (c.func == FUNC_RESET) begin
                        arm_slot(c.slot_id, int'(c.period));
                    end else if (c.func == FUNC_DESTROY) begin
                        tm_state[c.slot_id]   = SLOT_WAIT_DEL;
                        tm_waiting[c.slot_id] = 1'b0;
                    end else if (tm_waiting[c.slot_id] && tm_state[c.slot_id] == SLOT_RUNNING) begin
                        // answer to a pending fire: keep running or stop
                        tm_waiting[c.slot_id] = 1'b0;
                        if (!c.keep) tm_state[c.slot_id] = SLOT_STOPPED;
                    end
                    expect_result(KIND_DONE, c.slot_id, STATUS_OK, 1'b1);
                end
            end
            default: begin
                expect_result(KIND_DONE, 0, STATUS_OK, 1'b1);
            end
        endcase
    endtask

    // period mostly near the tick length so slots fire, with negatives and extremes
    function automatic int pick_period();
        int p;
        p = $urandom_range(99);
        if (p < 75) return $urandom_range(0, 3 * int'(tm_tick_len) + 3);
        if (p < 82) return -1;
        if (p < 87) return -int'($urandom_range(1, 16777216));
        if (p < 94) return int'($signed(25'($urandom())));
        if (p < 97) return 16777215;
        return 0;
    endfunction

    // random command, answers aimed at slots waiting for one where possible
    function automatic timer_cmd_t random_cmd();
        timer_cmd_t c;
        int r;
        int waiting[$];
        c.func    = FUNC_W'($urandom());
        c.slot_id = ID_W'($urandom());
        c.period  = PERIOD_W'($urandom());
        c.keep    = 1'($urandom());
        r = $urandom_range(99);
        if (r < 35) begin
            c.func = FUNC_TICK;
        end else if (r < 55) begin
            c.func   = FUNC_CREATE;
            c.period = PERIOD_W'(pick_period());
        end else if (r < 67) begin
            c.func   = FUNC_RESET;
            c.period = PERIOD_W'(pick_period());
        end else if (r < 76) begin
            c.func = FUNC_DESTROY;
        end else if (r < 95) begin
            c.func = FUNC_ANSWER;
            for (int i = 0; i < SLOTS; i++)
                if (tm_waiting[i] && tm_state[i] == SLOT_RUNNING) waiting.push_back(i);
            if (waiting.size() > 0 && $urandom_range(9) < 8)
                c.slot_id = ID_W'(waiting[$urandom_range(waiting.size() - 1)]);
        end else begin
            c.func = FUNC_W'($urandom_range(5, 7));
        end
        return c;
    endfunction

    task automatic issue_cmd(input logic [FUNC_W-1:0] func, input int id,
                             input int period, input logic keep);
        timer_cmd_t c;
        c.func    = func;
        c.slot_id = id[ID_W-1:0];
        c.period  = period[PERIOD_W-1:0];
        c.keep    = keep;
        while (cmd_backlog.size() >= 2) @(negedge i_clk);
        cmd_backlog.push_back(c);
        n_issued++;
    endtask

    task automatic wait_idle();
        while (cmd_backlog.size() != 0 || n_accepted != n_issued || due_results.size() != 0)
            @(negedge i_clk);
    endtask

    // tick length is only changed with the table quiet
    task automatic write_tick_len(input logic [TICK_W-1:0] value);
        wait_idle();
        repeat (SETTLE) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        tm_tick_len = value;
        n_cfg_writes++;
        @(negedge i_clk);
    endtask

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_timer_cmd(cur_cmd);
                n_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (cmd_backlog.size() > 0 && (calm || $urandom_range(99) >= 23)) begin
                    cur_cmd = cmd_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {2'b00, cur_cmd.keep, cur_cmd.period, cur_cmd.slot_id};
                    s_axis_tuser  <= cur_cmd.func;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge i_clk) begin
        timer_result_t got;
        timer_result_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind       = m_axis_tuser[0];
                got.slot_index = m_axis_tdata[3:0];
                got.status     = m_axis_tdata[5:4];
                got.last       = m_axis_tlast;
                n_results++;
                if (got.kind == KIND_FIRE) n_fires++;
                if (due_results.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result kind %0d slot %0d status %0d",
                                            got.kind, got.slot_index, got.status));
                end else begin
                    want = due_results.pop_front();
                    if (got.kind !== want.kind)
                        flag_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
                    if (got.slot_index !== want.slot_index)
                        flag_mismatch($sformatf("slot_index %0d, expected %0d",
                                                got.slot_index, want.slot_index));
                    if (got.status !== want.status)
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                got.status, want.status));
                    if (got.last !== want.last)
                        flag_mismatch($sformatf("tlast %0d, expected %0d", got.last, want.last));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_request && !hold_done) begin
                // one long hold-off so the command buffer fills and input stalls
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || $urandom_range(99) >= 23;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", quiet_cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus
    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tm_state[i]   = SLOT_IDLE;
            tm_period[i]  = 0;
            tm_elapsed[i] = 0;
            tm_waiting[i] = 1'b0;
        end
        tm_tick_len = TICK_LEN_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        write_tick_len(TICK_LEN_RESET);

        // directed corner cases on a fresh table
        issue_cmd(FUNC_TICK, 0, 0, 1'b0);                   // tick on an empty table
        issue_cmd(FUNC_CREATE, 15, 150, 1'b1);              // slot 0
        issue_cmd(FUNC_CREATE, 0, -1, 1'b0);                // slot 1, never expires
        issue_cmd(FUNC_CREATE, 0, 0, 1'b0);                 // slot 2, fires whenever counted
        issue_cmd(FUNC_CREATE, 0, 16777215, 1'b0);          // slot 3, largest period
        issue_cmd(FUNC_CREATE, 0, -16777216, 1'b0);         // slot 4, most negative period
        issue_cmd(FUNC_TICK, 0, 0, 1'b0);
        issue_cmd(FUNC_TICK, 0, 0, 1'b0);                   // slot 2 waiting, not counted
        issue_cmd(FUNC_ANSWER, 2, 0, 1'b1);
        issue_cmd(FUNC_ANSWER, 0, 0, 1'b0);                 // slot 0 stops
        issue_cmd(FUNC_ANSWER, 0, 0, 1'b1);                 // stray answer, stopped slot
        issue_cmd(FUNC_ANSWER, 5, 0, 1'b1);                 // stray answer, idle slot
        issue_cmd(FUNC_TICK, 0, 0, 1'b0);
        issue_cmd(FUNC_RESET, 2, 50, 1'b0);                 // reset while awaiting answer
        issue_cmd(FUNC_ANSWER, 2, 0, 1'b0);                 // cancelled answer, ignored
        issue_cmd(FUNC_DESTROY, 1, 0, 1'b0);
        issue_cmd(3'd5, 15, -1, 1'b1);                      // unused codes
        issue_cmd(3'd6, 0, 0, 1'b0);
        issue_cmd(3'd7, 15, -1, 1'b1);
        issue_cmd(FUNC_RESET, 15, 200, 1'b0);               // restart of an idle slot
        for (int k = 0; k < 11; k++)                        // fill the table, last has no slot
            issue_cmd(FUNC_CREATE, k, $urandom_range(0, 400), k[0]);
        issue_cmd(FUNC_TICK, 0, 0, 1'b0);                   // destroyed slot turns idle

        // random phases over several tick lengths
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_tick_len(10'd1000);
                1: write_tick_len(10'd1);
                2: write_tick_len(10'd0);
                default: write_tick_len(TICK_W'($urandom_range(2, 999)));
            endcase
            calm = (ph == 1);
            for (int k = 0; k < 18; k++) begin
                timer_cmd_t c;
                if (ph == 3 && k == 4) hold_request = 1'b1;
                c = random_cmd();
                issue_cmd(c.func, c.slot_id, int'(c.period), c.keep);
            end
        end
        calm = 1'b0;

        wait_idle();
        repeat (SETTLE) @(negedge i_clk);
        $display("covered %0d commands, %0d results with %0d timer fires, %0d tick length writes",
                 n_accepted, n_results, n_fires, n_cfg_writes);
        $display("directed corner cases, then random phases with stalls and a long hold-off");
        if (n_errors == 0 && due_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
